@@ sv/svpid_pkg.sv @@
// Shared widths, register codes, sequencer states and bundle types of the servo PID loop.
`default_nettype none
package svpid_pkg;

  localparam int POSITION_BITS = 16;
  localparam int POS_W  = POSITION_BITS;
  localparam int ERR_W  = POSITION_BITS + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int SUM_W  = 32;
  localparam int SSUM_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
  localparam int GAIN_W = 24;
  localparam int STEP_W = 8;
  localparam int OPD_W  = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
  localparam int PROD_W = GAIN_W + 1 + OPD_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int Q_BITS = 16;
  localparam int UC_W   = 24;
  localparam int P5_W   = UC_W + 3;
  localparam int EFF_W  = 8;
  localparam int PULSE_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam int EFFORT_LIMIT_INT = 100 * (1 << Q_BITS);
  localparam int PULSE_CENTER = 1500;

  localparam logic [GAIN_W-1:0] KP_RESET   = GAIN_W'(655360);
  localparam logic [GAIN_W-1:0] KI_RESET   = GAIN_W'(26214);
  localparam logic [GAIN_W-1:0] KD_RESET   = GAIN_W'(0);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP   = 2'd0,
    REG_KI   = 2'd1,
    REG_KD   = 2'd2,
    REG_STEP = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_SUM,
    S_MP,
    S_MD,
    S_MI,
    S_MACC,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic                     mul_en;
    logic                     acc_load;
    logic                     acc_add;
    logic [GAIN_W-1:0]        gain;
    logic signed [OPD_W-1:0]  opd;
  } mac_req_t;

endpackage
`default_nettype wire

@@ sv/svpid_mac.sv @@
// Shared gain multiplier with a registered product and an effort accumulator.
`default_nettype none
module svpid_mac (
  input  wire logic                            clk,
  input  wire svpid_pkg::mac_req_t             req,
  output logic signed [svpid_pkg::ACC_W-1:0]   acc
);
  import svpid_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  // The gain is unsigned, so it enters the signed multiply with a zero on top.
  assign prod_nxt = $signed({1'b0, req.gain}) * req.opd;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (req.acc_load) begin
      acc_r <= prod_ext;
    end else if (req.acc_add) begin
      acc_r <= acc_r + prod_ext;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

@@ sv/svpid_seq.sv @@
// Tick sequencer: error, integral, multiply schedule, clamp, pulse and setpoint update.
`default_nettype none
module svpid_seq (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire svpid_pkg::cfg_t                     cfg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [svpid_pkg::POS_W-1:0]  in_position,
  input  wire logic                                in_button_down,
  input  wire logic                                in_button_up,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [svpid_pkg::PULSE_W-1:0]            out_pulse_width_us,
  output logic signed [svpid_pkg::EFF_W-1:0]       out_effort,
  output logic signed [svpid_pkg::ERR_W-1:0]       out_error_value,
  output logic                                     out_clamped,
  output svpid_pkg::mac_req_t                      mac_req,
  input  wire logic signed [svpid_pkg::ACC_W-1:0]  acc
);
  import svpid_pkg::*;

  localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(EFFORT_LIMIT_INT);
  localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(EFFORT_LIMIT_INT);
  localparam logic signed [SSUM_W-1:0] SUM_MAX =
    {{(SSUM_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [SSUM_W-1:0] SUM_MIN =
    {{(SSUM_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

  seq_state_t state_r, state_nxt;

  logic signed [POS_W-1:0]  pos_r;
  logic                     dn_r, up_r;
  logic signed [ERR_W-1:0]  err_r, last_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [POS_W-1:0]         target_r;

  logic                     out_valid_r;
  logic [PULSE_W-1:0]       pulse_r;
  logic signed [EFF_W-1:0]  eff_r;
  logic signed [ERR_W-1:0]  oerr_r;
  logic                     clamp_r;

  logic                     fin_go;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [SSUM_W-1:0] ssum;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [UC_W-1:0]   u_c;
  logic signed [P5_W-1:0]   p5;
  logic                     clamp_nxt;
  logic [POS_W-1:0]         step_ext;
  logic [POS_W-1:0]         target_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_ERR;
      end
      S_ERR:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_MP;
      S_MP:   state_nxt = S_MD;
      S_MD:   state_nxt = S_MI;
      S_MI:   state_nxt = S_MACC;
      S_MACC: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs and multiplier schedule.
  always_comb begin
    in_ready         = 1'b0;
    fin_go           = 1'b0;
    mac_req.mul_en   = 1'b0;
    mac_req.acc_load = 1'b0;
    mac_req.acc_add  = 1'b0;
    mac_req.gain     = cfg.kp;
    mac_req.opd      = {{(OPD_W-ERR_W){err_r[ERR_W-1]}}, err_r};
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_MP: begin
        mac_req.mul_en = 1'b1;
      end
      S_MD: begin
        mac_req.mul_en   = 1'b1;
        mac_req.acc_load = 1'b1;
        mac_req.gain     = cfg.kd;
        mac_req.opd      = {{(OPD_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
      end
      S_MI: begin
        mac_req.mul_en  = 1'b1;
        mac_req.acc_add = 1'b1;
        mac_req.gain    = cfg.ki;
        mac_req.opd     = {{(OPD_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
      end
      S_MACC: mac_req.acc_add = 1'b1;
      S_FIN:  fin_go = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Error, saturating integral, clamp and pulse arithmetic.
  always_comb begin
    err_nxt = $signed({target_r[POS_W-1], target_r}) - $signed({pos_r[POS_W-1], pos_r});
    ssum = $signed({{(SSUM_W-SUM_W){sum_r[SUM_W-1]}}, sum_r})
         + $signed({{(SSUM_W-ERR_W){err_r[ERR_W-1]}}, err_r});
    if (ssum > SUM_MAX) begin
      sum_nxt = SUM_MAX[SUM_W-1:0];
    end else if (ssum < SUM_MIN) begin
      sum_nxt = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_nxt = ssum[SUM_W-1:0];
    end

    clamp_nxt = (acc > LIM_POS) || (acc < LIM_NEG);
    if (acc >= LIM_POS) begin
      u_c = LIM_POS[UC_W-1:0];
    end else if (acc <= LIM_NEG) begin
      u_c = LIM_NEG[UC_W-1:0];
    end else begin
      u_c = acc[UC_W-1:0];
    end
    // Five times the effort as a shift and add; the top bits are its floor.
    p5 = $signed({u_c[UC_W-1], u_c, 2'b00}) + $signed({{3{u_c[UC_W-1]}}, u_c});

    step_ext   = {{(POS_W-STEP_W){1'b0}}, cfg.step};
    target_nxt = target_r;
    if (err_r == '0) begin
      target_nxt = target_r + (up_r ? step_ext : '0) - (dn_r ? step_ext : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      last_r      <= '0;
      sum_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_SUM) begin
        sum_r <= sum_nxt;
      end
      if (fin_go) begin
        last_r   <= err_r;
        target_r <= target_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pos_r <= in_position;
      dn_r  <= in_button_down;
      up_r  <= in_button_up;
    end
    if (state_r == S_ERR) begin
      err_r <= err_nxt;
    end
    if (state_r == S_SUM) begin
      diff_r <= $signed({err_r[ERR_W-1], err_r}) - $signed({last_r[ERR_W-1], last_r});
    end
    if (fin_go) begin
      pulse_r <= PULSE_W'(PULSE_CENTER) + p5[P5_W-1:Q_BITS];
      eff_r   <= u_c[UC_W-1:Q_BITS];
      oerr_r  <= err_r;
      clamp_r <= clamp_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pulse_width_us = pulse_r;
  assign out_effort         = eff_r;
  assign out_error_value    = oerr_r;
  assign out_clamped        = clamp_r;

`ifndef ASSERT_OFF
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result appeared without a finishing step");

  a_effort_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (eff_r <= EFF_W'(100)) && (eff_r >= -EFF_W'(100)))
    else $error("effort outside clamp range");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pulse_r >= PULSE_W'(1000)) && (pulse_r <= PULSE_W'(2000)))
    else $error("pulse width outside servo range");

  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r != S_SUM) |=> $stable(sum_r))
    else $error("integral changed outside its update step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && state_r == S_FIN) |=> $stable(pulse_r) && $stable(oerr_r))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

@@ sv/servo_position_pid_loop.sv @@
// Servo position PID loop: gain registers and the sequencer with its shared multiplier.
//
// Channels: the input channel (in_valid/in_ready) carries one control tick: the
// encoder position and the two button levels. The result channel (out_valid/
// out_ready) returns one transaction per tick: pulse width, effort, error and
// the clamp flag. The configuration channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) writes kp, ki*dt, kd/dt and the step size; it is always ready.
// Schedule: an accepted tick passes the error, integral, kp, kd, ki,
// accumulate and finish steps before out_valid rises. The three gain products
// go one after another through a single 25x32 multiplier whose product is
// registered, and that schedule sets the cost of a tick. A new tick waits
// for the last one; in_ready is high only while the sequencer is idle.
// Reset: rst_n low restores the default gains and step size and clears the
// setpoint, the previous error and the integral. The block is ready on the
// first cycle after reset.
// Stall: a result waits in the output register. The next tick is accepted and
// computed meanwhile, and its final step holds until the waiting result is taken.
`default_nettype none
module servo_position_pid_loop (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [svpid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [svpid_pkg::GAIN_W-1:0]         cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [svpid_pkg::POS_W-1:0]   in_position,
  input  wire logic                                 in_button_down,
  input  wire logic                                 in_button_up,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [svpid_pkg::PULSE_W-1:0]             out_pulse_width_us,
  output logic signed [svpid_pkg::EFF_W-1:0]        out_effort,
  output logic signed [svpid_pkg::ERR_W-1:0]        out_error_value,
  output logic                                      out_clamped
);
  import svpid_pkg::*;

  cfg_t                     cfg_r;
  mac_req_t                 mac_req;
  logic signed [ACC_W-1:0]  acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp   <= KP_RESET;
      cfg_r.ki   <= KI_RESET;
      cfg_r.kd   <= KD_RESET;
      cfg_r.step <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP:   cfg_r.kp   <= cfg_data;
        REG_KI:   cfg_r.ki   <= cfg_data;
        REG_KD:   cfg_r.kd   <= cfg_data;
        REG_STEP: cfg_r.step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  svpid_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_position        (in_position),
    .in_button_down     (in_button_down),
    .in_button_up       (in_button_up),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pulse_width_us (out_pulse_width_us),
    .out_effort         (out_effort),
    .out_error_value    (out_error_value),
    .out_clamped        (out_clamped),
    .mac_req            (mac_req),
    .acc                (acc)
  );

  svpid_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .acc (acc)
  );

endmodule
`default_nettype wire
